[sv/icp_pkg.sv]
package icp_pkg;

    localparam int unsigned MAX_LEN_DEF = 1024;
    localparam int unsigned MAX_INV_DEF = 16383;

    localparam int unsigned LEN_IN_W = 11;
    localparam int unsigned INV_IN_W = 14;
    localparam int unsigned VAL_W    = 30;

    localparam logic [VAL_W-1:0] PRIME_MOD = 30'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIFF,
        ST_DONE
    } state_t;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } op_t;

endpackage

[sv/icp_mod_unit.sv]
module icp_mod_unit (
    input  icp_pkg::op_t                   op,
    input  logic [icp_pkg::VAL_W-1:0]      a,
    input  logic [icp_pkg::VAL_W-1:0]      b,
    output logic [icp_pkg::VAL_W-1:0]      y
);

    logic [icp_pkg::VAL_W:0] sum;
    logic [icp_pkg::VAL_W:0] wrap;

    // operands are always reduced, so one correction step is enough
    always_comb
    begin
        sum  = {1'b0, a} + {1'b0, b};
        wrap = {1'b0, a} + {1'b0, icp_pkg::PRIME_MOD} - {1'b0, b};
        case (op)
            icp_pkg::OP_ADD:
            begin
                if (sum >= {1'b0, icp_pkg::PRIME_MOD})
                    y = icp_pkg::VAL_W'(sum - {1'b0, icp_pkg::PRIME_MOD});
                else
                    y = icp_pkg::VAL_W'(sum);
            end
            icp_pkg::OP_SUB:
            begin
                if (a >= b)
                    y = a - b;
                else
                    y = icp_pkg::VAL_W'(wrap);
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule

[sv/inversion_count_permutations.sv]
// Channel   | Direction | Ports                       | Handshake
// ----------+-----------+-----------------------------+---------------------------------
// query     | in        | perm_length, inversions     | start high while busy is low
// result    | out       | count_mod                   | done high for exactly one cycle
//
// A query (n, c) walks lengths 2 to n, each over columns 0 to c; a query with
// n = 1 goes straight to done. Each column first reads the two row memories
// (registered reads), then uses the single modular add/subtract unit twice:
// prefix sum, then window difference.
// Reset clears the sequencer and counters only; the row memories need no
// clearing, since the first length pass supplies the initial row itself.
// The receiver cannot stall: the result is shown once, on the cycle done is high.
module inversion_count_permutations #(
    parameter int unsigned MAX_LEN = icp_pkg::MAX_LEN_DEF,
    parameter int unsigned MAX_INV = icp_pkg::MAX_INV_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [icp_pkg::LEN_IN_W-1:0]      perm_length,
    input  logic [icp_pkg::INV_IN_W-1:0]      inversions,
    output logic                              done,
    output logic [icp_pkg::VAL_W-1:0]         count_mod
);

    localparam int unsigned LW    = $clog2(MAX_LEN + 1);
    localparam int unsigned CW    = $clog2(MAX_INV + 1);
    localparam int unsigned DEPTH = MAX_INV + 1;
    localparam int unsigned CMPW  = (LW > CW) ? LW : CW;
    localparam int unsigned VW    = icp_pkg::VAL_W;

    // sequencer and counters
    icp_pkg::state_t state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;      // saturated n
    logic [CW-1:0]   top_reg, top_next;      // saturated c
    logic [LW-1:0]   i_reg, i_next;          // length being built
    logic [CW-1:0]   j_reg, j_next;          // column within the row
    logic            first_reg, first_next;  // first pass reads the unit row

    // datapath
    logic [VW-1:0]   p_reg, p_next;          // running value of the column
    logic [VW-1:0]   res_reg, res_next;
    logic [VW-1:0]   cnt_rd_reg;
    logic [VW-1:0]   pre_rd_reg;

    // row memories
    logic [VW-1:0]   count_mem  [DEPTH];
    logic [VW-1:0]   prefix_mem [DEPTH];

    logic            rd_en;
    logic            cnt_wr;
    logic            pre_wr;
    logic [CW-1:0]   pre_rd_addr;

    // shared unit
    icp_pkg::op_t    unit_op;
    logic [VW-1:0]   unit_a;
    logic [VW-1:0]   unit_b;
    logic [VW-1:0]   unit_y;

    logic            accept;
    logic [31:0]     n_ext;
    logic [31:0]     c_ext;
    logic [LW-1:0]   n_sat;
    logic [CW-1:0]   c_sat;
    logic            in_window;
    logic            col_zero;
    logic [VW-1:0]   old_val;

    icp_mod_unit u_mod_unit (
        .op (unit_op),
        .a  (unit_a),
        .b  (unit_b),
        .y  (unit_y)
    );

    assign accept    = start && !busy;
    assign in_window = CMPW'(j_reg) >= CMPW'(i_reg);
    assign col_zero  = (j_reg == '0);
    assign pre_rd_addr = j_reg - CW'(i_reg);

    // saturate the query to the supported range
    always_comb
    begin
        n_ext = 32'(perm_length);
        c_ext = 32'(inversions);
        if (n_ext == 32'd0)
            n_sat = LW'(1);
        else if (n_ext > 32'(MAX_LEN))
            n_sat = LW'(MAX_LEN);
        else
            n_sat = LW'(n_ext);
        if (c_ext > 32'(MAX_INV))
            c_sat = CW'(MAX_INV);
        else
            c_sat = CW'(c_ext);
    end

    // the first pass sees the row for length one: 1 at column zero, 0 elsewhere
    always_comb
    begin
        if (first_reg)
            old_val = col_zero ? VW'(1) : '0;
        else
            old_val = cnt_rd_reg;
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        top_next   = top_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        first_next = first_reg;
        case (state_reg)
            icp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    len_next   = n_sat;
                    top_next   = c_sat;
                    i_next     = LW'(2);
                    j_next     = '0;
                    first_next = 1'b1;
                    if (n_sat == LW'(1))
                        state_next = icp_pkg::ST_DONE;
                    else
                        state_next = icp_pkg::ST_READ;
                end
            end
            icp_pkg::ST_READ:
            begin
                state_next = icp_pkg::ST_ACCUM;
            end
            icp_pkg::ST_ACCUM:
            begin
                state_next = icp_pkg::ST_DIFF;
            end
            icp_pkg::ST_DIFF:
            begin
                if (j_reg == top_reg)
                begin
                    if (i_reg == len_reg)
                    begin
                        state_next = icp_pkg::ST_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + LW'(1);
                        j_next     = '0;
                        first_next = 1'b0;
                        state_next = icp_pkg::ST_READ;
                    end
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = icp_pkg::ST_READ;
                end
            end
            icp_pkg::ST_DONE:
            begin
                state_next = icp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = icp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs, memory strobes and unit operands
    always_comb
    begin
        busy    = (state_reg != icp_pkg::ST_IDLE);
        done    = (state_reg == icp_pkg::ST_DONE);
        rd_en   = 1'b0;
        cnt_wr  = 1'b0;
        pre_wr  = 1'b0;
        unit_op = icp_pkg::OP_ADD;
        unit_a  = '0;
        unit_b  = '0;
        case (state_reg)
            icp_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            icp_pkg::ST_ACCUM:
            begin
                // extend the prefix sum by the old entry of this column
                pre_wr = 1'b1;
                unit_a = col_zero ? '0 : p_reg;
                unit_b = old_val;
            end
            icp_pkg::ST_DIFF:
            begin
                // drop the prefix that falls out of the window of width i
                cnt_wr = 1'b1;
                unit_a = p_reg;
                if (in_window)
                begin
                    unit_op = icp_pkg::OP_SUB;
                    unit_b  = pre_rd_reg;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        p_next   = p_reg;
        res_next = res_reg;
        case (state_reg)
            icp_pkg::ST_IDLE:
            begin
                if (accept)
                    res_next = (c_sat == '0) ? VW'(1) : '0;
            end
            icp_pkg::ST_ACCUM:
            begin
                p_next = unit_y;
            end
            icp_pkg::ST_DIFF:
            begin
                res_next = unit_y;
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icp_pkg::ST_IDLE;
            len_reg   <= '0;
            top_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            top_reg   <= top_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        res_reg <= res_next;
    end

    // count row: read old entry, write rebuilt entry
    always_ff @(posedge clk)
    begin
        if (cnt_wr)
            count_mem[j_reg] <= unit_y;
        if (rd_en)
            cnt_rd_reg <= count_mem[j_reg];
    end

    // prefix row: written in column order, read i columns behind
    always_ff @(posedge clk)
    begin
        if (pre_wr)
            prefix_mem[j_reg] <= unit_y;
        if (rd_en)
            pre_rd_reg <= prefix_mem[pre_rd_addr];
    end

    assign count_mod = res_reg;

    // a transaction taken always makes the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("query accepted but block not busy");

    // the column never runs past the requested count
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (j_reg <= top_reg))
        else $error("column counter beyond requested count");

    // while walking rows, the length lies between 2 and n
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !done) |-> (i_reg >= LW'(2) && i_reg <= len_reg))
        else $error("length counter out of range");

    // the running value stays reduced before the window difference
    a_p_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == icp_pkg::ST_DIFF) |-> (p_reg < icp_pkg::PRIME_MOD))
        else $error("prefix sum not reduced");

    // results are reduced and shown for one cycle only
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_mod < icp_pkg::PRIME_MOD) ##1 !done)
        else $error("bad result transaction");

endmodule
